@@ rtl/sflm_pkg.sv @@
// Shared types, constants and helpers for the streaming substring match core.
`default_nettype none
package sflm_pkg;

  // Sizing
  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65536;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int CNT_W       = $clog2(MAX_TEXT + 1);
  localparam int PAT_W       = 2 * CFG_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE    = 2'd3;

  // Search modes
  localparam logic MODE_LEFTMOST  = 1'b0;
  localparam logic MODE_RIGHTMOST = 1'b1;

  // Input transaction payload
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start_position;
    logic             length_overflow;
  } out_item_t;

  // Per-cell control
  typedef struct packed {
    logic shift;
    logic active;
  } cell_ctl_t;

  // Top to tracker control
  typedef struct packed {
    logic             take;
    logic             last;
    logic             hit;
    logic [LEN_W-1:0] len;
    logic             mode;
  } trk_ctl_t;

  // Pick pattern byte idx out of the concatenated pattern registers
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                     input logic [PIDX_W-1:0] idx);
    return pat[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage
`default_nettype wire

@@ rtl/sflm_cell.sv @@
// One window cell: holds a past text byte, passes it on, compares it to its pattern byte.
`default_nettype none
module sflm_cell (
  input  wire logic                      clk,
  input  wire sflm_pkg::cell_ctl_t       ctl,
  input  wire logic [sflm_pkg::BYTE_W-1:0] din,
  input  wire logic [sflm_pkg::BYTE_W-1:0] pat,
  output logic      [sflm_pkg::BYTE_W-1:0] dout,
  output logic                           match
);

  logic [sflm_pkg::BYTE_W-1:0] data;

  // Byte register, advances once per counted byte
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= din;
    end
  end

  assign dout  = data;
  // Lanes beyond the pattern length never veto a hit
  assign match = !ctl.active || (data == pat);

endmodule
`default_nettype wire

@@ rtl/sflm_track.sv @@
// Match tracker: byte count, recorded match, overflow flag and result register.
`default_nettype none
module sflm_track (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sflm_pkg::trk_ctl_t  ctl,
  input  wire logic                out_ready,
  output logic                     counting,
  output logic                     out_valid,
  output sflm_pkg::out_item_t      out_item
);

  logic [sflm_pkg::CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic                       match_seen, match_seen_next;
  logic [sflm_pkg::POS_W-1:0] match_start, match_start_next;
  logic                       overflow_seen, overflow_seen_next;
  logic [sflm_pkg::CNT_W-1:0] seen_plus;
  logic [sflm_pkg::CNT_W-1:0] start_full;
  logic                       can_hit;
  sflm_pkg::out_item_t        result;

  assign counting   = (bytes_seen < sflm_pkg::CNT_W'(sflm_pkg::MAX_TEXT));
  assign seen_plus  = bytes_seen + sflm_pkg::CNT_W'(1);
  assign can_hit    = (seen_plus >= sflm_pkg::CNT_W'(ctl.len));
  assign start_full = seen_plus - sflm_pkg::CNT_W'(ctl.len);

  // Per-byte state update
  always_comb begin
    bytes_seen_next    = bytes_seen;
    match_seen_next    = match_seen;
    match_start_next   = match_start;
    overflow_seen_next = overflow_seen;
    if (ctl.take) begin
      if (!counting) begin
        overflow_seen_next = 1'b1;
      end else begin
        if (can_hit && ctl.hit &&
            (ctl.mode == sflm_pkg::MODE_RIGHTMOST || !match_seen)) begin
          match_start_next = start_full[sflm_pkg::POS_W-1:0];
          match_seen_next  = 1'b1;
        end
        bytes_seen_next = seen_plus;
      end
    end
  end

  // Result of the text that ends with this byte
  always_comb begin
    result.found           = match_seen_next;
    result.start_position  = match_seen_next ? match_start_next : '0;
    result.length_overflow = overflow_seen_next;
  end

  // Text state, cleared on reset and at end of text
  always_ff @(posedge clk) begin
    if (rst || (ctl.take && ctl.last)) begin
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      match_start   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      bytes_seen    <= bytes_seen_next;
      match_seen    <= match_seen_next;
      match_start   <= match_start_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take && ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.last) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

@@ rtl/substring_first_last_match_core.sv @@
// Latency: a result appears in the cycle after the final byte's transaction.
// Throughput: one text byte per cycle; the byte compare runs across a row of
// window cells, one per past byte, all checked in the same cycle.
// Input is stalled only while a result sits unaccepted in the output register.
// Reset (rst, synchronous) clears text state, the output valid and the
// configuration registers (pattern zero, length 1, leftmost mode).
`default_nettype none
module substring_first_last_match_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [sflm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sflm_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire sflm_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output sflm_pkg::out_item_t                     out_item
);

  logic [sflm_pkg::CFG_W-1:0] pattern_low;
  logic [sflm_pkg::CFG_W-1:0] pattern_high;
  logic [sflm_pkg::LEN_W-1:0] pattern_length;
  logic                       search_mode;
  logic [sflm_pkg::PAT_W-1:0] pattern;
  logic [sflm_pkg::LEN_W-1:0] len_eff;
  logic                       take;
  logic                       counting;
  logic [sflm_pkg::BYTE_W-1:0] win [1:sflm_pkg::WIN_DEPTH];
  logic [sflm_pkg::WIN_DEPTH:0] lane_match;
  sflm_pkg::trk_ctl_t         trk_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= sflm_pkg::LEN_W'(1);
      search_mode    <= sflm_pkg::MODE_LEFTMOST;
    end else if (cfg_write) begin
      case (cfg_index)
        sflm_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        sflm_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        sflm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[sflm_pkg::LEN_W-1:0];
        sflm_pkg::REG_SEARCH_MODE:    search_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pattern = {pattern_high, pattern_low};

  // Clamp length to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = sflm_pkg::LEN_W'(1);
    end else if (pattern_length > sflm_pkg::LEN_W'(sflm_pkg::MAX_PATTERN)) begin
      len_eff = sflm_pkg::LEN_W'(sflm_pkg::MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Handshake: blocked only by a result still waiting
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Newest byte lines up with the last pattern byte
  assign lane_match[0] = (in_item.text_byte == sflm_pkg::pattern_byte(
                           pattern, sflm_pkg::PIDX_W'(len_eff - sflm_pkg::LEN_W'(1))));

  // Row of window cells; cell j holds the byte j positions back
  for (genvar j = 1; j <= sflm_pkg::WIN_DEPTH; j++) begin : g_cell
    sflm_pkg::cell_ctl_t          ctl;
    logic [sflm_pkg::BYTE_W-1:0]  din;
    logic [sflm_pkg::BYTE_W-1:0]  pat;

    assign ctl.shift  = take && counting;
    assign ctl.active = (sflm_pkg::LEN_W'(j) < len_eff);
    assign pat = sflm_pkg::pattern_byte(
                   pattern, sflm_pkg::PIDX_W'(len_eff - sflm_pkg::LEN_W'(1) - sflm_pkg::LEN_W'(j)));
    if (j == 1) begin : g_head
      assign din = in_item.text_byte;
    end else begin : g_body
      assign din = win[j-1];
    end

    sflm_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .din   (din),
      .pat   (pat),
      .dout  (win[j]),
      .match (lane_match[j])
    );
  end

  // Tracker control
  always_comb begin
    trk_ctl.take = take;
    trk_ctl.last = in_item.end_of_text;
    trk_ctl.hit  = &lane_match;
    trk_ctl.len  = len_eff;
    trk_ctl.mode = search_mode;
  end

  sflm_track u_track (
    .clk       (clk),
    .rst       (rst),
    .ctl       (trk_ctl),
    .out_ready (out_ready),
    .counting  (counting),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

@@ rtl/sflm_checker.sv @@
// Port-level checks for the substring match core, bound to the top level.
`default_nettype none
module sflm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire sflm_pkg::in_item_t            in_item,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire sflm_pkg::out_item_t           out_item
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // No match reports position zero
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.found |-> out_item.start_position == '0)
    else $error("start position set without a match");

  // A new result only follows a final-byte transaction
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_item.end_of_text))
    else $error("result without end of text");

  // Input is held off while a result waits
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind substring_first_last_match_core sflm_checker u_sflm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

@@ verif/substring_first_last_match_core_test.sv @@
// Self-checking testbench for the streaming first/last substring match core.
module substring_first_last_match_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sflm_pkg::*;

  localparam int RANDOM_ITEMS  = 1700;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_LEN      = 4;
  // "WXYZ", byte 0 in the low bits
  localparam logic [CFG_W-1:0] LONG_PATTERN = 64'h5A59_5857;

  // Tracks the text state and predicts the match result of every text
  class match_scoreboard;
    logic [PAT_W-1:0]  pattern;
    logic [LEN_W-1:0]  pat_len;
    logic              mode;
    logic [BYTE_W-1:0] window [WIN_DEPTH];
    logic [CNT_W-1:0]  bytes_taken;
    logic              hit_seen;
    logic [POS_W-1:0]  hit_start;
    logic              overflow;
    out_item_t         expected_matches[$];
    int                errors;

    function new();
      pattern = '0;
      pat_len = LEN_W'(1);
      mode    = MODE_LEFTMOST;
      errors  = 0;
      restart_text();
    endfunction

    function void restart_text();
      foreach (window[k]) window[k] = '0;
      bytes_taken = '0;
      hit_seen    = 1'b0;
      hit_start   = '0;
      overflow    = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PATTERN_LOW:    pattern[CFG_W-1:0] = data;
        REG_PATTERN_HIGH:   pattern[PAT_W-1:CFG_W] = data;
        REG_PATTERN_LENGTH: pat_len = data[LEN_W-1:0];
        REG_SEARCH_MODE:    mode = data[0];
        default: ;
      endcase
    endfunction

    // One accepted text byte: update the search state, queue a result on the last byte
    function void take_text_byte(in_item_t it);
      int                len;
      bit                hit;
      logic [BYTE_W-1:0] b;
      out_item_t         res;
      len = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      if (bytes_taken >= MAX_TEXT) begin
        overflow = 1'b1;
      end else begin
        // a hit needs len bytes of this text, the window is never trusted beyond that
        hit = (int'(bytes_taken) + 1 >= len);
        for (int i = 0; i < len; i++) begin
          if (i == len - 1) begin
            b = it.text_byte;
          end else begin
            b = window[len - 2 - i];
          end
          if (b != pattern[i*BYTE_W +: BYTE_W]) hit = 1'b0;
        end
        if (hit && (mode == MODE_RIGHTMOST || !hit_seen)) begin
          hit_start = POS_W'(int'(bytes_taken) + 1 - len);
          hit_seen  = 1'b1;
        end
        for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = it.text_byte;
        bytes_taken++;
      end
      if (it.end_of_text) begin
        res.found           = hit_seen;
        res.start_position  = hit_seen ? hit_start : '0;
        res.length_overflow = overflow;
        expected_matches.push_back(res);
        restart_text();
      end
    endfunction

    function void check_match_result(out_item_t got);
      out_item_t want;
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none actual found=%0b start=%0d overflow=%0b",
                 $time, got.found, got.start_position, got.length_overflow);
        errors++;
        return;
      end
      want = expected_matches.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.start_position !== want.start_position) begin
        $display("%0t: start_position expected %0d actual %0d", $time,
                 want.start_position, got.start_position);
        errors++;
      end
      if (got.length_overflow !== want.length_overflow) begin
        $display("%0t: length_overflow expected %0b actual %0b", $time,
                 want.length_overflow, got.length_overflow);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  match_scoreboard   sb = new();
  bit                hold_req = 1'b0;
  bit                steady = 1'b0;
  int                quiet_cycles = 0;
  int                items_sent = 0;
  int                burst_left = 0;
  logic [PAT_W-1:0]  cur_pattern = '0;
  logic [BYTE_W-1:0] text_buf[$];
  logic [BYTE_W-1:0] alphabet[$];

  substring_first_last_match_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result checking and the no-progress counter
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_match_result(out_item);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL substring_first_last_match_core");
    $finish;
  end

  // Receiver: switches between randomly chosen stall styles; one long hold on request
  initial begin
    int style;
    int left;
    int tick;
    style = 0;
    left  = 0;
    tick  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(50, 300);
      end
      left--;
      tick++;
      case (style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= (tick % 5 > 2);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one byte, wait for the transaction, then maybe open a gap
  task automatic send_byte(input logic [BYTE_W-1:0] value, input bit closes);
    in_item_t it;
    it.text_byte   = value;
    it.end_of_text = closes;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.take_text_byte(it);
    items_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_span(input int first, input int count, input bit closes);
    for (int p = first; p < first + count; p++)
      send_byte(text_buf[p], closes && (p == first + count - 1));
  endtask

  // Drain every pending result and let the core go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] random_symbol();
    return alphabet[$urandom_range(0, alphabet.size() - 1)];
  endfunction

  // Small alphabets make hits common; the full byte range is the noise case
  function automatic void pick_alphabet();
    int n;
    alphabet.delete();
    case ($urandom_range(0, 6))
      0: for (int v = 0; v < 256; v++) alphabet.push_back(BYTE_W'(v));
      1: alphabet = {8'h00, 8'hFF};
      2: alphabet.push_back(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) alphabet.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic random_config();
    logic [CFG_W-1:0] len_word;
    for (int i = 0; i < MAX_PATTERN; i++) cur_pattern[i*BYTE_W +: BYTE_W] = random_symbol();
    len_word = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: len_word[LEN_W-1:0] = '0;
      1: len_word[LEN_W-1:0] = LEN_W'(MAX_PATTERN);
      2: len_word[LEN_W-1:0] = LEN_W'($urandom_range(MAX_PATTERN + 1, 31));
      3: len_word[LEN_W-1:0] = LEN_W'(1);
      default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(2, 6));
    endcase
    write_reg(REG_PATTERN_LOW, cur_pattern[CFG_W-1:0]);
    write_reg(REG_PATTERN_HIGH, cur_pattern[PAT_W-1:CFG_W]);
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_SEARCH_MODE, {$urandom, $urandom});
  endtask

  // Random text; half the time the pattern is planted once or twice (truncated at the end)
  function automatic void build_text();
    int len;
    int at;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    text_buf.delete();
    repeat (len) text_buf.push_back(random_symbol());
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 2)) begin
        at = $urandom_range(0, len - 1);
        for (int j = 0; j < MAX_PATTERN && at + j < len; j++)
          text_buf[at + j] = cur_pattern[j*BYTE_W +: BYTE_W];
      end
    end
  endfunction

  // Lowercase filler with "WXYZ" planted at up to three offsets
  task automatic send_long_text(input int total, input int m0, input int m1, input int m2);
    logic [BYTE_W-1:0] v;
    int                marks[3];
    int                off;
    marks = '{m0, m1, m2};
    for (int p = 0; p < total; p++) begin
      v = BYTE_W'($urandom_range(8'h61, 8'h7A));
      foreach (marks[k]) begin
        off = p - marks[k];
        if (off >= 0 && off < LONG_LEN) v = LONG_PATTERN[off*BYTE_W +: BYTE_W];
      end
      send_byte(v, p == total - 1);
    end
  endtask

  // Stimulus
  initial begin
    int base;
    int phase;
    int cut;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: one-byte zero pattern, NUL is ordinary text
    text_buf = {8'h00, 8'hFF, 8'h00};
    send_span(0, 3, 1'b1);
    settle();

    // Length zero acts as one; rightmost mode
    write_reg(REG_PATTERN_LOW, 64'hFF);
    write_reg(REG_PATTERN_LENGTH, '0);
    write_reg(REG_SEARCH_MODE, MODE_RIGHTMOST);
    text_buf = {8'hFF, 8'h01, 8'hFF};
    send_span(0, 3, 1'b1);
    settle();

    // Oversized length clamps to the full pattern; text is exactly the pattern
    write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    text_buf.delete();
    for (int i = 0; i < MAX_PATTERN; i++) text_buf.push_back(sb.pattern[i*BYTE_W +: BYTE_W]);
    send_span(0, MAX_PATTERN, 1'b1);
    // Text shorter than the pattern; old window bytes must not complete a hit
    text_buf = {sb.pattern[PAT_W-1 -: BYTE_W]};
    send_span(0, 1, 1'b1);
    settle();

    // Search mode flipped in the middle of a text
    write_reg(REG_PATTERN_LOW, 64'h41);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_SEARCH_MODE, MODE_LEFTMOST);
    text_buf = {8'h41, 8'h41, 8'h41};
    send_span(0, 2, 1'b0);
    settle();
    write_reg(REG_SEARCH_MODE, MODE_RIGHTMOST);
    send_span(2, 1, 1'b1);
    settle();

    // Random phases: new alphabet and registers, then a batch of texts
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      pick_alphabet();
      random_config();
      if (phase == 1) begin
        // receiver holds off while one-byte texts keep coming, so the input backs up
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (20) begin
          text_buf = {random_symbol()};
          send_span(0, 1, 1'b1);
        end
      end
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 12)) begin
        build_text();
        if ($urandom_range(0, 9) == 0 && text_buf.size() > 1) begin
          // change a register part way through the text
          cut = $urandom_range(1, text_buf.size() - 1);
          send_span(0, cut, 1'b0);
          settle();
          if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_SEARCH_MODE, {$urandom, $urandom});
          end else begin
            write_reg(REG_PATTERN_LENGTH, CFG_W'($urandom_range(0, 31)));
          end
          send_span(cut, text_buf.size() - cut, 1'b1);
        end else begin
          send_span(0, text_buf.size(), 1'b1);
        end
      end
      settle();
      phase++;
    end

    // Texts at and past the position counter range
    steady = 1'b1;
    write_reg(REG_PATTERN_LOW, LONG_PATTERN);
    write_reg(REG_PATTERN_HIGH, '0);
    write_reg(REG_PATTERN_LENGTH, CFG_W'(LONG_LEN));
    write_reg(REG_SEARCH_MODE, MODE_RIGHTMOST);
    send_long_text(MAX_TEXT, 100, MAX_TEXT - LONG_LEN, -1000);
    send_long_text(MAX_TEXT + 5, 100, MAX_TEXT - 6, MAX_TEXT - 2);
    settle();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS substring_first_last_match_core");
    end else begin
      $display("FAIL substring_first_last_match_core");
    end
    $finish;
  end

endmodule
